[rtl/tssc_pkg.sv]
// Package for the tachometer speed step controller: widths, types, codes, constants.
`timescale 1ns / 1ps
package tssc_pkg;

    localparam int CAP_W   = 24;
    localparam int SPEED_W = 27;
    localparam int DUTY_W  = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = SPEED_W;
    localparam int CNT_W   = $clog2(SPEED_W);

    typedef logic [CAP_W-1:0]   cap_t;
    typedef logic [SPEED_W-1:0] speed_t;
    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [CFG_AW-1:0]  cfg_idx_t;
    typedef logic [CFG_DW-1:0]  cfg_data_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_SPEED_GOAL = 3'd0;
    localparam cfg_idx_t REG_DUTY_STEP  = 3'd1;
    localparam cfg_idx_t REG_DUTY_HIGH  = 3'd2;
    localparam cfg_idx_t REG_DUTY_LOW   = 3'd3;

    localparam speed_t SPEED_NUM        = 27'd80000000;
    localparam speed_t TARGET_RESET     = 27'd0;
    localparam duty_t  DUTY_STEP_RESET  = 16'd100;
    localparam duty_t  DUTY_HIGH_RESET  = 16'd35000;
    localparam duty_t  DUTY_LOW_RESET   = 16'd2000;
    localparam duty_t  DUTY_LEVEL_RESET = 16'd30000;
    localparam cap_t   LAST_CAP_RESET   = 24'd0;

    // Last iteration index of the restoring divider (one quotient bit per step)
    localparam cnt_t DIV_LAST = CNT_W'(SPEED_W - 1);

    // Controller to datapath
    typedef struct packed {
        logic load;    // take the capture beat, start the divide
        logic step;    // one divider iteration
        logic commit;  // update duty, load the result register
    } tssc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;  // current iteration is the final one
    } tssc_status_t;

endpackage

[rtl/tssc_if.sv]
// Valid/ready channel interfaces for capture beats and result beats.
`timescale 1ns / 1ps
interface tssc_cap_if;
    logic              valid;
    logic              ready;
    tssc_pkg::cap_t    capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

interface tssc_res_if;
    logic              valid;
    logic              ready;
    tssc_pkg::cap_t    period;
    tssc_pkg::speed_t  speed;
    tssc_pkg::duty_t   duty;

    modport source (output valid, output period, output speed, output duty, input ready);
    modport sink   (input valid, input period, input speed, input duty, output ready);
endinterface

[rtl/tach_speed_step_controller.sv]
// Top level of the tachometer speed step controller.
// A capture beat accepted in idle runs through the divide state, then the update state, which commits it
// to the result register and raises the result valid; the serial divider runs 27 iterations in between.
// A new capture is taken only after the previous one is committed, but the result register lets the next
// capture in while an earlier result still waits. Reset (rst_n low, asynchronous): registers return to
// their defaults, last capture 0, duty level 30000, no result pending.
`timescale 1ns / 1ps
module tach_speed_step_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    tssc_cap_if.sink             capture,
    tssc_res_if.source           result,
    input  logic                 cfg_we,
    input  tssc_pkg::cfg_idx_t   cfg_addr,
    input  tssc_pkg::cfg_data_t  cfg_wdata
);
    import tssc_pkg::*;

    // Command and status between the sequencer and the datapath
    tssc_cmd_t    cmd;
    tssc_status_t status;

    // Sequencer: takes a capture beat only when idle, then runs the divide
    // for a fixed count, then commits into the result register once that
    // register is free (empty, or being drained in the same cycle).
    tssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (capture.valid),
        .in_ready  (capture.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: period from the previous capture, 80000000 / period one
    // quotient bit per cycle, then the duty step clamped to the high and low limits.
    tssc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .capture_time (capture.capture_time),
        .cmd          (cmd),
        .status       (status),
        .period       (result.period),
        .speed        (result.speed),
        .duty         (result.duty)
    );

endmodule

[rtl/tssc_ctrl.sv]
// Controller state machine: sequences load, divide and commit, owns the result valid.
`timescale 1ns / 1ps
module tssc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tssc_pkg::tssc_cmd_t    cmd,
    input  tssc_pkg::tssc_status_t status
);
    import tssc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/tssc_dpath.sv]
// Datapath: config registers, period, serial divider, duty step and clamp, result register.
`timescale 1ns / 1ps
module tssc_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  tssc_pkg::cfg_idx_t     cfg_addr,
    input  tssc_pkg::cfg_data_t    cfg_wdata,
    input  tssc_pkg::cap_t         capture_time,
    input  tssc_pkg::tssc_cmd_t    cmd,
    output tssc_pkg::tssc_status_t status,
    output tssc_pkg::cap_t         period,
    output tssc_pkg::speed_t       speed,
    output tssc_pkg::duty_t        duty
);
    import tssc_pkg::*;

    speed_t target_reg;
    duty_t  step_reg;
    duty_t  high_reg;
    duty_t  low_reg;
    cap_t   last_cap_reg;
    duty_t  level_reg;

    cap_t   divisor_reg;
    cap_t   rem_reg;
    speed_t quo_reg;
    cnt_t   cnt_reg;

    cap_t   period_reg;
    speed_t speed_reg;
    duty_t  duty_reg;

    logic [CAP_W:0]  trial;
    logic [CAP_W:0]  diff;
    logic            fits;
    cap_t            rem_next;
    speed_t          quo_next;
    speed_t          speed_val;
    logic [DUTY_W:0] up;
    logic [DUTY_W:0] down;
    duty_t           up_sat;
    duty_t           down_sat;
    duty_t           level_next;

    // Restoring divide: shift in one dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SPEED_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
        quo_next = {quo_reg[SPEED_W-2:0], fits};
    end

    assign status.div_last = (cnt_reg == DIV_LAST);

    // Zero period saturates
    assign speed_val = (divisor_reg == '0) ? SPEED_NUM : quo_reg;

    always_comb
    begin
        up       = {1'b0, level_reg} + {1'b0, step_reg};
        down     = {1'b0, level_reg} - {1'b0, step_reg};
        up_sat   = (up >= {1'b0, high_reg}) ? high_reg : up[DUTY_W-1:0];
        down_sat = (down[DUTY_W] || (down[DUTY_W-1:0] <= low_reg)) ?
                   low_reg : down[DUTY_W-1:0];
        level_next = (speed_val < target_reg) ? up_sat : down_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            step_reg     <= DUTY_STEP_RESET;
            high_reg     <= DUTY_HIGH_RESET;
            low_reg      <= DUTY_LOW_RESET;
            last_cap_reg <= LAST_CAP_RESET;
            level_reg    <= DUTY_LEVEL_RESET;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SPEED_GOAL: target_reg <= cfg_wdata;
                    REG_DUTY_STEP:  step_reg   <= cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_HIGH:  high_reg   <= cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_LOW:   low_reg    <= cfg_wdata[DUTY_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.load)
            begin
                last_cap_reg <= capture_time;
                cnt_reg      <= '0;
            end
            else if (cmd.step)
                cnt_reg <= cnt_reg + cnt_t'(1);
            if (cmd.commit)
                level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            divisor_reg <= last_cap_reg - capture_time;
            rem_reg     <= '0;
            quo_reg     <= SPEED_NUM;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.commit)
        begin
            period_reg <= divisor_reg;
            speed_reg  <= speed_val;
            duty_reg   <= level_next;
        end
    end

    assign period = period_reg;
    assign speed  = speed_reg;
    assign duty   = duty_reg;

endmodule

[rtl/tssc_checker.sv]
// Port-level checker for the tachometer speed step controller, bound to the top level.
`timescale 1ns / 1ps
module tssc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  tssc_pkg::cap_t    period,
    input  tssc_pkg::speed_t  speed,
    input  tssc_pkg::duty_t   duty
);
    import tssc_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(period) && $stable(speed)
            && $stable(duty))
        else $error("result beat changed while stalled");

    // One capture at a time: the divide keeps the input closed
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("capture accepted while divide in progress");

    // Quotient never exceeds the numerator
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed <= SPEED_NUM)
        else $error("speed out of range");

    // Zero period saturates
    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && period == '0 |-> speed == SPEED_NUM)
        else $error("zero period not saturated");

endmodule

bind tach_speed_step_controller tssc_checker u_tssc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (capture.valid),
    .in_ready  (capture.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .period    (result.period),
    .speed     (result.speed),
    .duty      (result.duty)
);
